[rtl/wpwm_pkg.sv]
// Shared constants, types and helpers for the word permutation window match unit.
package wpwm_pkg;

  localparam int WordLenMax  = 8;
  localparam int WordsMax    = 16;
  localparam int TextLenMax  = 65536;

  localparam int WordW   = 8 * WordLenMax;
  localparam int IdxW    = $clog2(WordsMax);
  localparam int PhW     = $clog2(WordLenMax);
  localparam int CntW    = $clog2(WordsMax + 1);
  localparam int LenW    = $clog2(WordLenMax + 1);
  localparam int PosW    = $clog2(TextLenMax) + 1;
  localparam int StartW  = 16;
  localparam int HfAw    = PhW + IdxW;
  localparam int RingAw  = PhW + IdxW + IdxW;
  localparam int HfW     = IdxW + CntW;
  localparam int OqDepth = 4;
  localparam int OqAw    = $clog2(OqDepth);

  localparam logic [1:0] FUNC_KEY     = 2'd0;
  localparam logic [1:0] FUNC_TEXT    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic CFG_WORD_LEN   = 1'b0;
  localparam logic CFG_WORD_COUNT = 1'b1;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } match_t;

  // Byte mask that keeps the low wl characters of a packed word.
  function automatic logic [WordW-1:0] word_mask(input logic [LenW-1:0] wl);
    logic [WordW-1:0] m;
    m = '0;
    for (int k = 0; k < WordLenMax; k++) begin
      if (LenW'(k) < wl) begin
        m[8*k +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

[rtl/wpwm_kw_table.sv]
// Keyword table: distinct keywords, their multiplicities and the parallel lookups.
module wpwm_kw_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          load_en_i,
  input  logic [wpwm_pkg::WordW-1:0]    load_word_i,
  input  logic [wpwm_pkg::WordW-1:0]    text_word_i,
  output wpwm_pkg::match_t              text_match_o,
  input  logic [wpwm_pkg::IdxW-1:0]     mult_idx_i,
  output logic [wpwm_pkg::CntW-1:0]     mult_o
);

  logic [wpwm_pkg::WordW-1:0] table_q [wpwm_pkg::WordsMax];
  logic [wpwm_pkg::CntW-1:0]  mult_q  [wpwm_pkg::WordsMax];
  logic [wpwm_pkg::CntW-1:0]  distinct_q;
  wpwm_pkg::match_t           load_match;

  always_comb begin
    load_match   = '0;
    text_match_o = '0;
    for (int i = 0; i < wpwm_pkg::WordsMax; i++) begin
      if (wpwm_pkg::CntW'(i) < distinct_q) begin
        if (table_q[i] == load_word_i) begin
          load_match.hit = 1'b1;
          load_match.idx = wpwm_pkg::IdxW'(i);
        end
        if (table_q[i] == text_word_i) begin
          text_match_o.hit = 1'b1;
          text_match_o.idx = wpwm_pkg::IdxW'(i);
        end
      end
    end
  end

  assign mult_o = mult_q[mult_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distinct_q <= '0;
      for (int i = 0; i < wpwm_pkg::WordsMax; i++) mult_q[i] <= '0;
    end else if (clear_i) begin
      distinct_q <= '0;
      for (int i = 0; i < wpwm_pkg::WordsMax; i++) mult_q[i] <= '0;
    end else if (load_en_i) begin
      if (load_match.hit) begin
        mult_q[load_match.idx] <= mult_q[load_match.idx] + 1'b1;
      end else if (distinct_q < wpwm_pkg::CntW'(wpwm_pkg::WordsMax)) begin
        mult_q[distinct_q[wpwm_pkg::IdxW-1:0]] <= wpwm_pkg::CntW'(1);
        distinct_q <= distinct_q + 1'b1;
      end
    end
  end

  // Table payload carries no reset; entries at or above the distinct count are never compared.
  always_ff @(posedge clk_i) begin
    if (load_en_i && !clear_i && !load_match.hit &&
        distinct_q < wpwm_pkg::CntW'(wpwm_pkg::WordsMax)) begin
      table_q[distinct_q[wpwm_pkg::IdxW-1:0]] <= load_word_i;
    end
  end

endmodule

[rtl/word_permutation_window_match_unit.sv]
// Top level: keyword loading, text word pipeline, occurrence rings and result queue.
//
//   channel | direction | handshake               | payload
//   in      | in        | in_valid_i / in_stall_o | func_i, ch_i
//   out     | out       | out_valid_o/out_stall_i | start_pos_o
//   cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while in_stall_o is low; the edge that takes a text word registers
// its lookup and head/fill read, then stage 1 (ring read and write-back) and stage 2 (window
// update) carry the word on to the result queue.
// The head/fill memory and the occurrence ring memory each see one read and one write
// per cycle; a same-entry hit on the head/fill memory is forwarded from the write-back.
// Reset and restart clear the control state at once; no clearing pass is needed.
// Text stalls only when the four-entry result queue could overflow; a restart waits
// until the word pipeline is empty.
module word_permutation_window_match_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [4:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  input  logic [7:0]                     ch_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wpwm_pkg::StartW-1:0]    start_pos_o
);

  localparam int WordW  = wpwm_pkg::WordW;
  localparam int IdxW   = wpwm_pkg::IdxW;
  localparam int PhW    = wpwm_pkg::PhW;
  localparam int CntW   = wpwm_pkg::CntW;
  localparam int LenW   = wpwm_pkg::LenW;
  localparam int PosW   = wpwm_pkg::PosW;
  localparam int StartW = wpwm_pkg::StartW;
  localparam int HfW    = wpwm_pkg::HfW;
  localparam int HfDepth   = 1 << wpwm_pkg::HfAw;
  localparam int RingDepth = 1 << wpwm_pkg::RingAw;

  // configuration
  logic [LenW-1:0] wl_q;
  logic [CntW-1:0] wc_q;
  logic [LenW-1:0] cfg_wl;
  logic [CntW-1:0] cfg_wc;

  // load and text state
  logic [CntW-1:0]  loaded_q;
  logic [WordW-1:0] buf_q;
  logic [LenW-1:0]  lcnt_q;
  logic [WordW-1:0] tw_q;
  logic [PosW-1:0]  pos_q;
  logic [PhW-1:0]   nph_q;

  logic             in_acc, key_acc, txt_go, word_done, clear;
  logic [WordW-1:0] mask, buf_new, tw_new;
  logic             load_en;
  logic [PosW-1:0]  pos_inc, j_full;
  wpwm_pkg::match_t tmatch;
  logic [CntW-1:0]  s1_mult;

  // head/fill memory
  logic [HfW-1:0]  hf_mem [HfDepth];
  logic [HfDepth-1:0] hv_q;
  logic [wpwm_pkg::HfAw-1:0] r0;

  // ring memory
  logic [StartW-1:0] ring_mem [RingDepth];

  // stage 1
  logic             s1_v_q, s1_hit_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [PhW-1:0]   s1_ph_q;
  logic [StartW-1:0] s1_j_q;
  logic [PosW-1:0]  s1_jn_q;
  logic [HfW-1:0]   hf_rd_q, fwd_val_q;
  logic             hv_rd_q, fwd_q;
  logic [HfW-1:0]   hf_cur, hf_new;
  logic [IdxW-1:0]  head, head_n, slot;
  logic [CntW-1:0]  fill, fill_p, fill_n;
  logic             pop;

  // stage 2
  logic             s2_v_q, s2_hit_q, s2_pop_q;
  logic [PhW-1:0]   s2_ph_q;
  logic [PosW-1:0]  s2_jn_q;
  logic [StartW-1:0] pos_rd_q;
  logic [PosW-1:0]  ws_q [wpwm_pkg::WordLenMax];
  logic [PosW-1:0]  ws, ws1, span;
  logic             hit_out;

  // result queue
  logic [StartW-1:0]       oq_q [wpwm_pkg::OqDepth];
  logic [wpwm_pkg::OqAw-1:0] oq_wr_q, oq_rd_q;
  logic [wpwm_pkg::OqAw:0]   oq_cnt_q;
  logic [wpwm_pkg::OqAw+1:0] busy;
  logic                    oq_push, oq_pop;

  always_comb begin
    cfg_wl = cfg_data_i[LenW-1:0];
    if (cfg_wl == '0) cfg_wl = LenW'(1);
    if (cfg_wl > LenW'(wpwm_pkg::WordLenMax)) cfg_wl = LenW'(wpwm_pkg::WordLenMax);
    cfg_wc = cfg_data_i[CntW-1:0];
    if (cfg_wc == '0) cfg_wc = CntW'(1);
    if (cfg_wc > CntW'(wpwm_pkg::WordsMax)) cfg_wc = CntW'(wpwm_pkg::WordsMax);
  end

  assign busy = (wpwm_pkg::OqAw+2)'(oq_cnt_q) + (wpwm_pkg::OqAw+2)'(s1_v_q)
              + (wpwm_pkg::OqAw+2)'(s2_v_q);

  assign in_stall_o = ((func_i == wpwm_pkg::FUNC_TEXT) &&
                       busy >= (wpwm_pkg::OqAw+2)'(wpwm_pkg::OqDepth)) ||
                      ((func_i == wpwm_pkg::FUNC_RESTART) && (s1_v_q || s2_v_q));

  assign in_acc  = in_valid_i && !in_stall_o;
  assign key_acc = in_acc && func_i == wpwm_pkg::FUNC_KEY && loaded_q < wc_q;
  assign txt_go  = in_acc && func_i == wpwm_pkg::FUNC_TEXT && loaded_q >= wc_q && !pos_q[PosW-1];
  assign clear   = cfg_we_i || (in_acc && func_i == wpwm_pkg::FUNC_RESTART);

  assign mask    = wpwm_pkg::word_mask(wl_q);
  assign buf_new = {buf_q[WordW-9:0], ch_i} & mask;
  assign tw_new  = {tw_q[WordW-9:0], ch_i};
  assign load_en = key_acc && (lcnt_q + 1'b1 == wl_q);

  assign pos_inc   = pos_q + 1'b1;
  assign word_done = txt_go && (pos_inc >= PosW'(wl_q));
  assign j_full    = pos_inc - PosW'(wl_q);
  assign r0        = {nph_q, tmatch.idx};

  wpwm_kw_table u_kw_table (
    .clk_i,
    .rst_ni,
    .clear_i      (clear),
    .load_en_i    (load_en),
    .load_word_i  (buf_new),
    .text_word_i  (tw_new & mask),
    .text_match_o (tmatch),
    .mult_idx_i   (s1_idx_q),
    .mult_o       (s1_mult)
  );

  // configuration and front-end state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q     <= LenW'(1);
      wc_q     <= CntW'(1);
      loaded_q <= '0;
      buf_q    <= '0;
      lcnt_q   <= '0;
      tw_q     <= '0;
      pos_q    <= '0;
      nph_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wpwm_pkg::CFG_WORD_LEN:   wl_q <= cfg_wl;
          wpwm_pkg::CFG_WORD_COUNT: wc_q <= cfg_wc;
          default: ;
        endcase
      end
      if (clear) begin
        loaded_q <= '0;
        buf_q    <= '0;
        lcnt_q   <= '0;
        tw_q     <= '0;
        pos_q    <= '0;
        nph_q    <= '0;
      end else begin
        if (key_acc) begin
          if (load_en) begin
            loaded_q <= loaded_q + 1'b1;
            buf_q    <= '0;
            lcnt_q   <= '0;
          end else begin
            buf_q  <= buf_new;
            lcnt_q <= lcnt_q + 1'b1;
          end
        end
        if (txt_go) begin
          tw_q  <= tw_new;
          pos_q <= pos_inc;
        end
        if (word_done) begin
          nph_q <= (nph_q + 1'b1 == PhW'(wl_q)) || (wl_q == LenW'(wpwm_pkg::WordLenMax) &&
                   nph_q == PhW'(wpwm_pkg::WordLenMax - 1)) ? '0 : nph_q + 1'b1;
        end
      end
    end
  end

  // stage 1: head/fill update, ring push and oldest-position read
  always_comb begin
    hf_cur = fwd_q ? fwd_val_q : (hv_rd_q ? hf_rd_q : '0);
    head   = hf_cur[HfW-1:CntW];
    fill   = hf_cur[CntW-1:0];
    pop    = fill >= s1_mult;
    head_n = pop ? head + 1'b1 : head;
    fill_p = pop ? fill - 1'b1 : fill;
    slot   = head_n + fill_p[IdxW-1:0];
    fill_n = fill_p + 1'b1;
    hf_new = {head_n, fill_n};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      fwd_q  <= 1'b0;
      hv_q   <= '0;
    end else begin
      s1_v_q <= word_done && !clear;
      s2_v_q <= s1_v_q;
      fwd_q  <= word_done && tmatch.hit && s1_v_q && s1_hit_q && r0 == {s1_ph_q, s1_idx_q};
      if (clear) begin
        hv_q <= '0;
      end else if (s1_v_q && s1_hit_q) begin
        hv_q[{s1_ph_q, s1_idx_q}] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hf_rd_q   <= hf_mem[r0];
    hv_rd_q   <= hv_q[r0];
    fwd_val_q <= hf_new;
    s1_hit_q  <= tmatch.hit;
    s1_idx_q  <= tmatch.idx;
    s1_ph_q   <= nph_q;
    s1_j_q    <= j_full[StartW-1:0];
    s1_jn_q   <= pos_inc;
    if (s1_v_q && s1_hit_q) begin
      hf_mem[{s1_ph_q, s1_idx_q}] <= hf_new;
      ring_mem[{s1_ph_q, s1_idx_q, slot}] <= s1_j_q;
    end
    pos_rd_q <= ring_mem[{s1_ph_q, s1_idx_q, head}];
    s2_hit_q <= s1_hit_q;
    s2_pop_q <= s1_hit_q && pop;
    s2_ph_q  <= s1_ph_q;
    s2_jn_q  <= s1_jn_q;
  end

  // stage 2: window start update and match test
  always_comb begin
    ws   = ws_q[s2_ph_q];
    ws1  = (s2_pop_q && PosW'(pos_rd_q) >= ws) ? PosW'(pos_rd_q) + PosW'(wl_q) : ws;
    span = PosW'(wc_q) * PosW'(wl_q);
    hit_out = s2_v_q && s2_hit_q && s2_jn_q >= ws1 && (s2_jn_q - ws1) == span;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < wpwm_pkg::WordLenMax; p++) ws_q[p] <= PosW'(p);
    end else if (clear) begin
      for (int p = 0; p < wpwm_pkg::WordLenMax; p++) ws_q[p] <= PosW'(p);
    end else if (s2_v_q) begin
      // foreign word restarts the window right after it
      ws_q[s2_ph_q] <= s2_hit_q ? ws1 : s2_jn_q;
    end
  end

  // result queue
  assign oq_push     = hit_out;
  assign out_valid_o = oq_cnt_q != '0;
  assign oq_pop      = out_valid_o && !out_stall_i;
  assign start_pos_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) oq_wr_q <= oq_wr_q + 1'b1;
      if (oq_pop)  oq_rd_q <= oq_rd_q + 1'b1;
      oq_cnt_q <= oq_cnt_q + (wpwm_pkg::OqAw+1)'(oq_push) - (wpwm_pkg::OqAw+1)'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_q[oq_wr_q] <= ws1[StartW-1:0];
  end

endmodule
